[rtl/bxgcd_pkg.sv]
// bxgcd_pkg: widths, payload structs, microcode encoding and control ROM
// for the binary extended GCD block. No dependencies.
`timescale 1ns / 1ps

package bxgcd_pkg;

   localparam int OPERAND_WIDTH   = 31;
   localparam int DIVISOR_WIDTH   = 31;
   localparam int COEFF_OUT_WIDTH = 32;
   // coefficients run a few bits above the operand width so halving stays exact
   localparam int COEFF_WIDTH     = OPERAND_WIDTH + 3;
   localparam int SHIFT_WIDTH     = $clog2(OPERAND_WIDTH);
   localparam int STEP_WIDTH      = 3;

   typedef struct packed {
      logic [OPERAND_WIDTH-1:0] first_operand;
      logic [OPERAND_WIDTH-1:0] second_operand;
   } req_type;

   typedef struct packed {
      logic [DIVISOR_WIDTH-1:0]          divisor;
      logic signed [COEFF_OUT_WIDTH-1:0] coeff_first;
      logic signed [COEFF_OUT_WIDTH-1:0] coeff_second;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_STRIP,
      OP_HALVE_P,
      OP_HALVE_Q,
      OP_SUBTRACT,
      OP_OUT_GCD,
      OP_OUT_ZERO
   } dp_op_type;

   typedef enum logic [2:0] {
      COND_NOT_START,
      COND_ANY_ZERO,
      COND_BOTH_EVEN,
      COND_P_EVEN,
      COND_Q_EVEN,
      COND_P_NE_Q,
      COND_ALWAYS
   } cond_type;

   typedef logic [STEP_WIDTH-1:0] step_type;

   localparam step_type STEP_IDLE     = 3'd0;
   localparam step_type STEP_CHECK    = 3'd1;
   localparam step_type STEP_STRIP    = 3'd2;
   localparam step_type STEP_HALVE_P  = 3'd3;
   localparam step_type STEP_HALVE_Q  = 3'd4;
   localparam step_type STEP_SUBTRACT = 3'd5;
   localparam step_type STEP_FINISH   = 3'd6;
   localparam step_type STEP_ZERO     = 3'd7;

   // condition true: go to target, otherwise fall through to the next step
   typedef struct packed {
      dp_op_type op;
      cond_type  cond;
      step_type  target;
   } ucode_word_type;

   typedef struct packed {
      logic any_zero;
      logic both_even;
      logic p_even;
      logic q_even;
      logic p_ne_q;
   } dp_flags_type;

   function automatic ucode_word_type ucode_rom(input step_type step);
      ucode_word_type word;
      unique case (step)
         STEP_IDLE:     word = '{OP_NOP,      COND_NOT_START, STEP_IDLE};
         STEP_CHECK:    word = '{OP_NOP,      COND_ANY_ZERO,  STEP_ZERO};
         STEP_STRIP:    word = '{OP_STRIP,    COND_BOTH_EVEN, STEP_STRIP};
         STEP_HALVE_P:  word = '{OP_HALVE_P,  COND_P_EVEN,    STEP_HALVE_P};
         STEP_HALVE_Q:  word = '{OP_HALVE_Q,  COND_Q_EVEN,    STEP_HALVE_Q};
         STEP_SUBTRACT: word = '{OP_SUBTRACT, COND_P_NE_Q,    STEP_HALVE_P};
         STEP_FINISH:   word = '{OP_OUT_GCD,  COND_ALWAYS,    STEP_IDLE};
         STEP_ZERO:     word = '{OP_OUT_ZERO, COND_ALWAYS,    STEP_IDLE};
         default:       word = '{OP_NOP,      COND_ALWAYS,    STEP_IDLE};
      endcase
      return word;
   endfunction

endpackage

[rtl/bxgcd_sequencer.sv]
// bxgcd_sequencer: step counter, control ROM lookup and branch logic.
// Depends on bxgcd_pkg.
`timescale 1ns / 1ps

module bxgcd_sequencer
   import bxgcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  dp_flags_type flags,
   output dp_op_type    op,
   output logic         busy
);

   step_type       pc_ff, pc_in;
   ucode_word_type word;
   logic           taken;

   assign word = ucode_rom(pc_ff);
   assign op   = word.op;
   assign busy = (pc_ff != STEP_IDLE);

   always_comb begin
      case (word.cond)
         COND_NOT_START: taken = !start;
         COND_ANY_ZERO:  taken = flags.any_zero;
         COND_BOTH_EVEN: taken = flags.both_even;
         COND_P_EVEN:    taken = flags.p_even;
         COND_Q_EVEN:    taken = flags.q_even;
         COND_P_NE_Q:    taken = flags.p_ne_q;
         COND_ALWAYS:    taken = 1'b1;
         default:        taken = 1'b1;
      endcase
      pc_in = taken ? word.target : pc_ff + STEP_WIDTH'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

[rtl/bxgcd_datapath.sv]
// bxgcd_datapath: operand, remainder and coefficient registers with the
// shift/add unit that each microcode op drives. Depends on bxgcd_pkg.
`timescale 1ns / 1ps

module bxgcd_datapath
   import bxgcd_pkg::*;
(
   input  logic         clock,
   input  logic         load,
   input  req_type      req,
   input  dp_op_type    op,
   output dp_flags_type flags,
   output logic         result_valid,
   output rsp_type      result
);

   logic [OPERAND_WIDTH-1:0]      a_ff, a_in, b_ff, b_in, p_ff, p_in, q_ff, q_in;
   logic [SHIFT_WIDTH-1:0]        shift_ff, shift_in;
   logic signed [COEFF_WIDTH-1:0] u_ff, u_in, v_ff, v_in, r_ff, r_in, s_ff, s_in;
   logic signed [COEFF_WIDTH-1:0] a_ext, b_ext, x_tmp, y_tmp;
   logic [OPERAND_WIDTH-1:0]      scaled;

   assign a_ext = signed'(COEFF_WIDTH'(a_ff));
   assign b_ext = signed'(COEFF_WIDTH'(b_ff));

   assign flags.any_zero  = (a_ff == '0) || (b_ff == '0);
   assign flags.both_even = !(a_ff[0] | b_ff[0]);
   assign flags.p_even    = !p_ff[0];
   assign flags.q_even    = !q_ff[0];
   assign flags.p_ne_q    = (p_ff != q_ff);

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      shift_in = shift_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      r_in     = r_ff;
      s_in     = s_ff;
      x_tmp    = '0;
      y_tmp    = '0;
      if (load) begin
         a_in     = req.first_operand;
         b_in     = req.second_operand;
         shift_in = '0;
      end else begin
         case (op)
            OP_STRIP: begin
               if (!(a_ff[0] | b_ff[0])) begin
                  a_in     = a_ff >> 1;
                  b_in     = b_ff >> 1;
                  shift_in = shift_ff + SHIFT_WIDTH'(1);
               end else begin
                  p_in = a_ff;
                  q_in = b_ff;
                  u_in = COEFF_WIDTH'(1);
                  v_in = '0;
                  r_in = '0;
                  s_in = COEFF_WIDTH'(1);
               end
            end
            OP_HALVE_P: begin
               if (!p_ff[0]) begin
                  p_in = p_ff >> 1;
                  // make both coefficients even before halving
                  if (u_ff[0] | v_ff[0]) begin
                     x_tmp = u_ff - b_ext;
                     y_tmp = v_ff + a_ext;
                  end else begin
                     x_tmp = u_ff;
                     y_tmp = v_ff;
                  end
                  u_in = x_tmp >>> 1;
                  v_in = y_tmp >>> 1;
               end
            end
            OP_HALVE_Q: begin
               if (!q_ff[0]) begin
                  q_in = q_ff >> 1;
                  if (r_ff[0] | s_ff[0]) begin
                     x_tmp = r_ff - b_ext;
                     y_tmp = s_ff + a_ext;
                  end else begin
                     x_tmp = r_ff;
                     y_tmp = s_ff;
                  end
                  r_in = x_tmp >>> 1;
                  s_in = y_tmp >>> 1;
               end
            end
            OP_SUBTRACT: begin
               if (p_ff > q_ff) begin
                  p_in = p_ff - q_ff;
                  u_in = u_ff - r_ff;
                  v_in = v_ff - s_ff;
               end else begin
                  q_in = q_ff - p_ff;
                  r_in = r_ff - u_ff;
                  s_in = s_ff - v_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      p_ff     <= p_in;
      q_ff     <= q_in;
      shift_ff <= shift_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      r_ff     <= r_in;
      s_ff     <= s_in;
   end

   assign scaled = p_ff << shift_ff;

   always_comb begin
      result_valid = 1'b0;
      result       = '0;
      case (op)
         OP_OUT_GCD: begin
            result_valid        = 1'b1;
            result.divisor      = DIVISOR_WIDTH'(scaled);
            result.coeff_first  = COEFF_OUT_WIDTH'(u_ff);
            result.coeff_second = COEFF_OUT_WIDTH'(v_ff);
         end
         OP_OUT_ZERO: begin
            result_valid        = 1'b1;
            result.divisor      = DIVISOR_WIDTH'(a_ff | b_ff);
            result.coeff_first  = COEFF_OUT_WIDTH'(a_ff != '0);
            result.coeff_second = COEFF_OUT_WIDTH'((a_ff == '0) && (b_ff != '0));
         end
         default: begin
         end
      endcase
   end

endmodule

[rtl/binary_extended_gcd.sv]
// binary_extended_gcd: top level of the binary extended GCD block; ties the
// microcode sequencer to the datapath and registers the result. Uses bxgcd_pkg.
`timescale 1ns / 1ps

// Binary extended GCD. Pulse start with both operands on req_data while busy
// is low; that edge accepts the transaction. Some cycles later rsp_strobe is
// high for exactly one cycle with the gcd on rsp_data.divisor and the Bezout
// coefficients on rsp_data.coeff_first / coeff_second (two's complement).
// The coefficients satisfy u*a' + v*b' = odd part of the gcd, where a' and b'
// are the operands with their shared power of two removed. There is no
// backpressure on the result side: capture the result on the strobe cycle.
// A zero operand returns the other operand with coefficient 1 beside it;
// both zero returns all zeros.
// Sequencing: an eight-entry microprogram (ucode_rom in the package, idle
// step included) runs one step per cycle. From the accept edge, a nonzero
// pair passes through a check step; strip steps, one per shared factor of two
// and a last one that loads the loop registers; a halving step per halving of
// either remainder; passes of the subtract loop, each an odd test on each
// remainder and the subtraction; and an output step. The strobe shows in the
// cycle after the output step. Zero operands go from the check step to the
// zero output step. busy drops as the result is registered, so the next start
// may be given in the same cycle the strobe shows.

module binary_extended_gcd
   import bxgcd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   dp_op_type    op;
   dp_flags_type flags;
   logic         accept;
   logic         result_valid;
   rsp_type      result;
   logic         rsp_strobe_ff;
   rsp_type      rsp_data_ff;

   // transaction accepted on start while the sequencer sits in idle
   assign accept = start && !busy;

   bxgcd_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .op    (op),
      .busy  (busy)
   );

   bxgcd_datapath u_datapath (
      .clock        (clock),
      .load         (accept),
      .req          (req_data),
      .op           (op),
      .flags        (flags),
      .result_valid (result_valid),
      .result       (result)
   );

   // output register: one-cycle strobe with the payload
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= result_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (result_valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

[test/binary_extended_gcd_test.sv]
// binary_extended_gcd_test: self-checking testbench for the binary extended GCD block.
// Needs bxgcd_pkg and binary_extended_gcd; builds its own expected results from the operands.
`timescale 1ns / 1ps

module binary_extended_gcd_test;
   import bxgcd_pkg::*;

   localparam int RANDOM_ITEMS  = 500;
   localparam int CYCLE_LIMIT   = 1_000_000;
   // a little over the worst-case run of the microprogram
   localparam int DRAIN_CYCLES  = 300;
   localparam logic [OPERAND_WIDTH-1:0] OPERAND_MAX = '1;

   // random operand shapes; each steers the datapath into a different corner
   typedef enum int {
      SHAPE_WIDE,
      SHAPE_SHARED_TWOS,
      SHAPE_SMALL,
      SHAPE_ZERO,
      SHAPE_MULTIPLE,
      SHAPE_POWER,
      SHAPE_ODD
   } stimulus_shape;

   // Expected gcd/Bezout results, in acceptance order.
   class bezout_scoreboard;
      rsp_type     pending_gcds[$];
      int unsigned mismatches = 0;

      // arithmetic halving of an even two's complement value
      function logic [63:0] halve(logic [63:0] x);
         return {x[63], x[63:1]};
      endfunction

      // binary extended Euclid, coefficients kept in 64 bits
      function rsp_type bezout_predict(req_type item);
         logic [63:0] a, b, u, v, r, s, p, q;
         int unsigned shift;
         rsp_type     res;
         a = 64'(item.first_operand);
         b = 64'(item.second_operand);
         // a zero operand short-circuits: the other operand, coefficient 1 beside it
         if (a == 0 || b == 0) begin
            res.divisor      = DIVISOR_WIDTH'(a | b);
            res.coeff_first  = (a != 0) ? 32'sd1 : 32'sd0;
            res.coeff_second = (a == 0 && b != 0) ? 32'sd1 : 32'sd0;
            return res;
         end
         shift = 0;
         while (((a | b) & 64'd1) == 0) begin
            a = a >> 1;
            b = b >> 1;
            shift++;
         end
         u = 64'd1; v = 64'd0; r = 64'd0; s = 64'd1;
         p = a;     q = b;
         while (q != 0) begin
            while (p[0] == 1'b0) begin
               p = p >> 1;
               if (u[0] | v[0]) begin
                  u = u - b;
                  v = v + a;
               end
               u = halve(u);
               v = halve(v);
            end
            while (q[0] == 1'b0) begin
               q = q >> 1;
               if (r[0] | s[0]) begin
                  r = r - b;
                  s = s + a;
               end
               r = halve(r);
               s = halve(s);
            end
            if (p > q) begin
               p = p - q;
               u = u - r;
               v = v - s;
            end else begin
               q = q - p;
               r = r - u;
               s = s - v;
            end
         end
         res.divisor      = DIVISOR_WIDTH'(p << shift);
         res.coeff_first  = u[COEFF_OUT_WIDTH-1:0];
         res.coeff_second = v[COEFF_OUT_WIDTH-1:0];
         return res;
      endfunction

      function void note_request(req_type item);
         pending_gcds.push_back(bezout_predict(item));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_gcds.size() == 0) begin
            $error("unexpected result: divisor %0d, coeff_first %0d, coeff_second %0d",
                   got.divisor, got.coeff_first, got.coeff_second);
            mismatches++;
            return;
         end
         want = pending_gcds.pop_front();
         if (got.divisor !== want.divisor) begin
            $error("divisor: expected %0d, got %0d", want.divisor, got.divisor);
            mismatches++;
         end
         if (got.coeff_first !== want.coeff_first) begin
            $error("coeff_first: expected %0d, got %0d", want.coeff_first, got.coeff_first);
            mismatches++;
         end
         if (got.coeff_second !== want.coeff_second) begin
            $error("coeff_second: expected %0d, got %0d", want.coeff_second,
                   got.coeff_second);
            mismatches++;
         end
      endfunction
   endclass

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   bezout_scoreboard gcd_board = new();
   int unsigned      cycle_count = 0;

   binary_extended_gcd uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #4 clock = ~clock;

   // Results cannot be held off: every strobe cycle is one transaction.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         gcd_board.check_result(rsp_data);
      end
   end

   // Watchdog against a hung block.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("binary_extended_gcd verification failed");
         $finish;
      end
   end

   // Present one transaction and hold it until the block takes it.
   // start stays high into the next transaction unless the burst ends here;
   // then the sender goes quiet, sometimes briefly (gap lands while busy),
   // sometimes long enough that the block sits idle before the next start.
   task automatic send_operands(input req_type item, input bit burst_ends);
      int unsigned gap;
      req_data <= item;
      start    <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      gcd_board.note_request(item);
      if (burst_ends) begin
         start <= 1'b0;
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 160) : $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      req_type                  directed_items[$];
      req_type                  item;
      logic [OPERAND_WIDTH-1:0] x, y;
      stimulus_shape            shape;
      int unsigned              k;
      int unsigned              burst_left;
      int                       total;

      // corners: zero operands, all-ones, powers of two, shared factors of two,
      // alternating bit patterns, equal operands and a Fibonacci pair
      directed_items.push_back(req_type'{'0, '0});
      directed_items.push_back(req_type'{'0, 31'd1});
      directed_items.push_back(req_type'{31'd1, '0});
      directed_items.push_back(req_type'{'0, OPERAND_MAX});
      directed_items.push_back(req_type'{OPERAND_MAX, '0});
      directed_items.push_back(req_type'{31'd1, 31'd1});
      directed_items.push_back(req_type'{OPERAND_MAX, OPERAND_MAX});
      directed_items.push_back(req_type'{31'd1, OPERAND_MAX});
      directed_items.push_back(req_type'{OPERAND_MAX, 31'd1});
      directed_items.push_back(req_type'{OPERAND_MAX, OPERAND_MAX - 31'd1});
      directed_items.push_back(req_type'{31'h4000_0000, 31'h4000_0000});
      directed_items.push_back(req_type'{31'h4000_0000, 31'h2000_0000});
      directed_items.push_back(req_type'{31'h4000_0000, 31'h3000_0000});
      directed_items.push_back(req_type'{31'h4000_0000, OPERAND_MAX});
      directed_items.push_back(req_type'{31'd6, 31'd4});
      directed_items.push_back(req_type'{31'd12, 31'd18});
      directed_items.push_back(req_type'{31'd240, 31'd46});
      directed_items.push_back(req_type'{31'd3, 31'd5});
      directed_items.push_back(req_type'{31'd1836311903, 31'd1134903170});
      directed_items.push_back(req_type'{31'd1134903170, 31'd1836311903});
      directed_items.push_back(req_type'{31'h5555_5555, 31'h2AAA_AAAA});
      directed_items.push_back(req_type'{31'd2147483629, 31'd1});

      total      = directed_items.size() + RANDOM_ITEMS;
      burst_left = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < total; n++) begin
         if (n < directed_items.size()) begin
            item = directed_items[n];
         end else begin
            shape = stimulus_shape'($urandom_range(SHAPE_WIDE, SHAPE_ODD));
            case (shape)
               SHAPE_SHARED_TWOS: begin
                  k = $urandom_range(1, OPERAND_WIDTH - 1);
                  x = OPERAND_WIDTH'($urandom) << k;
                  y = OPERAND_WIDTH'($urandom) << k;
               end
               SHAPE_SMALL: begin
                  x = OPERAND_WIDTH'($urandom_range(0, 300));
                  y = OPERAND_WIDTH'($urandom_range(0, 300));
               end
               SHAPE_ZERO: begin
                  // one side zero, now and then both
                  x = ($urandom_range(0, 1) != 0) ? OPERAND_WIDTH'($urandom) : '0;
                  y = (x == 0 && $urandom_range(0, 3) != 0) ? OPERAND_WIDTH'($urandom) : '0;
               end
               SHAPE_MULTIPLE: begin
                  x = OPERAND_WIDTH'($urandom_range(1, 1 << 20));
                  y = OPERAND_WIDTH'(x * $urandom_range(1, 9));
               end
               SHAPE_POWER: begin
                  x    = '0;
                  x[$urandom_range(0, OPERAND_WIDTH - 1)] = 1'b1;
                  y    = OPERAND_WIDTH'($urandom);
               end
               SHAPE_ODD: begin
                  x = OPERAND_WIDTH'($urandom) | 1'b1;
                  y = OPERAND_WIDTH'($urandom) | 1'b1;
               end
               default: begin
                  x = OPERAND_WIDTH'($urandom);
                  y = OPERAND_WIDTH'($urandom);
               end
            endcase
            if ($urandom_range(0, 1) != 0) item = '{y, x};
            else item = '{x, y};
         end
         if (burst_left == 0) burst_left = $urandom_range(1, 24);
         burst_left--;
         send_operands(item, burst_left == 0 || n == total - 1);
      end

      // all transactions in: let outstanding results land, then watch for strays
      while (gcd_board.pending_gcds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (gcd_board.pending_gcds.size() != 0) begin
         $error("%0d results never arrived", gcd_board.pending_gcds.size());
         gcd_board.mismatches++;
      end
      if (gcd_board.mismatches == 0) begin
         $display("binary_extended_gcd verification clean");
      end else begin
         $display("binary_extended_gcd verification failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/bxgcd_pkg.sv
rtl/bxgcd_sequencer.sv
rtl/bxgcd_datapath.sv
rtl/binary_extended_gcd.sv
test/binary_extended_gcd_test.sv
